// ===== hw/rtl/spq_pkg.sv =====
// package for the sorted priority queue: sizes, operation codes and cell control
// used by spq_cell and sorted_priority_queue_top; no dependencies
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int INDEX_W  = $clog2(CAPACITY);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                    capture;  // latch compare flags against key
    logic                    insert;   // accepted insert, shift right
    logic                    remove;   // remove, shift left from first match
    logic signed [KEY_W-1:0] key;      // port key on capture, held key on apply
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// one cell of the sorted key chain: holds a key and its compare flags
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    in_range,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic                    left_gt,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic                    seen_in,
  output logic signed [KEY_W-1:0] key,
  output logic                    gt,
  output logic                    seen_out,
  output logic                    first
);

  logic eq;

  // match chain: a cell at or past the first match
  assign seen_out = seen_in | eq;
  assign first    = eq & ~seen_in;

  // compare flags on capture, key shifts on apply
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      gt <= in_range && (key > ctrl.key);
      eq <= in_range && (key == ctrl.key);
    end
    if (ctrl.insert && !gt) begin
      key <= left_gt ? ctrl.key : left_key;
    end else if (ctrl.remove && seen_out) begin
      key <= right_key;
    end
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// sorted priority queue: a chain of key cells in descending order
// depends on spq_pkg and spq_cell
// the result strobe is registered as the apply state ends, after the accepting edge
// no new transaction is accepted while busy; busy is high for the apply cycle
// the cells compare in the accept cycle and shift in the apply cycle
// reset clears the count and control; the receiver cannot stall results
module sorted_priority_queue_top import spq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode,
  input  logic signed [KEY_W-1:0] key_value,
  output logic                    done,
  output logic                    found,
  output logic [POS_W-1:0]        position,
  output logic [COUNT_W-1:0]      entry_count,
  output logic signed [KEY_W-1:0] head_key,
  output logic                    head_valid,
  output logic                    rejected
);

  typedef enum logic {ST_IDLE, ST_APPLY} state_t;

  state_t                  state;
  mode_t                   mode_q;
  logic signed [KEY_W-1:0] key_q;
  logic [COUNT_W-1:0]      count;
  logic                    capture;
  logic                    full;
  cell_ctrl_t              ctrl;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_gt;
  logic [CAPACITY-1:0]     cell_seen;
  logic [CAPACITY-1:0]     cell_first;
  logic [CAPACITY-1:0]     in_range;
  logic [INDEX_W-1:0]      match_index;

  assign busy    = (state == ST_APPLY);
  assign capture = start && !busy;
  assign full    = (count == COUNT_W'(CAPACITY));

  // control broadcast to the chain
  always_comb begin
    ctrl.capture = capture;
    ctrl.insert  = busy && (mode_q == MODE_INSERT) && !full;
    ctrl.remove  = busy && (mode_q == MODE_REMOVE);
    ctrl.key     = busy ? key_q : key_value;
  end

  // cells holding a key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      in_range[i] = COUNT_W'(i) < count;
    end
  end

  // chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .in_range (in_range[g]),
      .left_key ((g == 0) ? key_q : cell_key[(g == 0) ? 0 : g - 1]),
      .left_gt  ((g == 0) ? 1'b1 : cell_gt[(g == 0) ? 0 : g - 1]),
      .right_key((g == CAPACITY - 1) ? cell_key[g]
                 : cell_key[(g == CAPACITY - 1) ? g : g + 1]),
      .seen_in  ((g == 0) ? 1'b0 : cell_seen[(g == 0) ? 0 : g - 1]),
      .key      (cell_key[g]),
      .gt       (cell_gt[g]),
      .seen_out (cell_seen[g]),
      .first    (cell_first[g])
    );
  end

  // index of the first match, one-hot to binary
  always_comb begin
    match_index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_first[i]) begin
        match_index = match_index | INDEX_W'(i);
      end
    end
  end

  // sequencer, count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      done     <= 1'b0;
      found    <= 1'b0;
      position <= '0;
      rejected <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (capture) begin
            mode_q <= mode_t'(mode);
            key_q  <= key_value;
            state  <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          done     <= 1'b1;
          found    <= 1'b0;
          position <= '0;
          rejected <= 1'b0;
          case (mode_q)
            MODE_INSERT: begin
              if (full) begin
                rejected <= 1'b1;
              end else begin
                found <= 1'b1;
                count <= count + COUNT_W'(1);
              end
            end
            MODE_REMOVE: begin
              if (cell_seen[CAPACITY-1]) begin
                found <= 1'b1;
                count <= count - COUNT_W'(1);
              end
            end
            MODE_FIND: begin
              if (cell_seen[CAPACITY-1]) begin
                found    <= 1'b1;
                position <= POS_W'(match_index);
              end
            end
            default: begin
            end
          endcase
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // head straight from the chain, count from the count register
  assign entry_count = count;
  assign head_valid  = (count != '0);
  assign head_key    = head_valid ? cell_key[0] : '0;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("apply did not finish in one cycle");

  a_reject_only_full: assert property (@(posedge clk) disable iff (rst)
    done && rejected |-> !found && (count == COUNT_W'(CAPACITY)))
    else $error("reject without full queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(count))
    else $error("count changed outside apply");

endmodule
